// ===== rtl/pmq_pkg.sv =====
// ----------------------------------------------------------------------------
// pmq_pkg
// Types, codes and constants shared by the priority message queue modules.
// ----------------------------------------------------------------------------
package pmq_pkg;

  localparam int PMQ_DEPTH_DEFAULT = 16;

  localparam logic OP_SEND = 1'b0;
  localparam logic OP_RECV = 1'b1;

  localparam logic ST_OK      = 1'b0;
  localparam logic ST_REFUSED = 1'b1;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_MARK = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_MARK  = 1'b1;

  localparam logic [4:0] HIGH_MARK_RST = 5'd16;
  localparam logic [3:0] LOW_MARK_RST  = 4'd0;

  typedef struct packed {
    logic        operation;
    logic [7:0]  msg_priority;
    logic [63:0] payload;
    logic [7:0]  msg_len;
  } pmq_in_t;

  typedef struct packed {
    logic        status;
    logic [7:0]  out_priority;
    logic [63:0] out_payload;
    logic [7:0]  out_length;
    logic        full_flag;
    logic [4:0]  entry_count;
    logic [11:0] bytes_held;
  } pmq_out_t;

  typedef struct packed {
    logic [7:0]  priority_val;
    logic [63:0] payload;
    logic [7:0]  length;
  } pmq_entry_t;

  typedef enum logic [2:0] {
    PMQ_IDLE,
    PMQ_DISPATCH,
    PMQ_SCAN,
    PMQ_PICK,
    PMQ_SHIFT,
    PMQ_DONE
  } pmq_state_t;

  typedef struct packed {
    logic load;
    logic send_commit;
    logic refuse;
    logic ptr_clr;
    logic scan_rd;
    logic ptr_best;
    logic shift_rd;
    logic recv_commit;
  } pmq_cmd_t;

  typedef struct packed {
    logic is_recv;
    logic send_ok;
    logic empty;
    logic scan_last;
    logic shift_more;
  } pmq_status_t;

endpackage

// ===== rtl/priority_message_queue.sv =====
// ----------------------------------------------------------------------------
// priority_message_queue
// Bounded priority message queue with high/low watermark flow control.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; exactly one
// result follows on out_item, marked by a one-cycle out_strobe that cannot be
// held off. A send, and any refused transaction, is settled in the dispatch
// state and then strobed from the result register. A receive strobes only
// after the store is scanned and compacted: the single read port of the
// message store is stepped once per cycle, first over every held entry to
// find the highest priority, then over the entries behind the removed one to
// close the gap. Configuration writes take effect at once and should only be
// issued while busy is low and no result is pending.
module priority_message_queue #(
  parameter int QUEUE_DEPTH = pmq_pkg::PMQ_DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  pmq_pkg::pmq_in_t               in_item,
  output logic                           out_strobe,
  output pmq_pkg::pmq_out_t              out_item,
  input  logic                           cfg_we,
  input  logic [pmq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pmq_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import pmq_pkg::*;

  pmq_cmd_t    cmd;
  pmq_status_t st;

  pmq_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .busy (busy),
    .st   (st),
    .cmd  (cmd)
  );

  pmq_dp #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .st        (st),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

endmodule

// ===== rtl/pmq_ram.sv =====
// ----------------------------------------------------------------------------
// pmq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pmq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/pmq_ctrl.sv =====
// ----------------------------------------------------------------------------
// pmq_ctrl
// Sequencer: accepts a transaction, dispatches send or receive, steps the
// priority scan and the compaction of the queue after a removal.
// ----------------------------------------------------------------------------
module pmq_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  pmq_pkg::pmq_status_t st,
  output pmq_pkg::pmq_cmd_t    cmd
);
  import pmq_pkg::*;

  pmq_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PMQ_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    busy      = (state_r != PMQ_IDLE);
    unique case (state_r)
      PMQ_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = PMQ_DISPATCH;
        end
      end
      PMQ_DISPATCH: begin
        if (st.is_recv) begin
          if (st.empty) begin
            cmd.refuse = 1'b1;
            state_nxt  = PMQ_IDLE;
          end else begin
            cmd.ptr_clr = 1'b1;
            state_nxt   = PMQ_SCAN;
          end
        end else begin
          if (st.send_ok) begin
            cmd.send_commit = 1'b1;
          end else begin
            cmd.refuse = 1'b1;
          end
          state_nxt = PMQ_IDLE;
        end
      end
      PMQ_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (st.scan_last) begin
          state_nxt = PMQ_PICK;
        end
      end
      PMQ_PICK: begin
        cmd.ptr_best = 1'b1;
        state_nxt    = PMQ_SHIFT;
      end
      PMQ_SHIFT: begin
        if (st.shift_more) begin
          cmd.shift_rd = 1'b1;
        end else begin
          state_nxt = PMQ_DONE;
        end
      end
      PMQ_DONE: begin
        cmd.recv_commit = 1'b1;
        state_nxt       = PMQ_IDLE;
      end
      default: begin
        state_nxt = PMQ_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/pmq_dp.sv =====
// ----------------------------------------------------------------------------
// pmq_dp
// Datapath: message store, occupancy and byte counters, watermark flag,
// scan pointer, best-entry compare and result register.
// ----------------------------------------------------------------------------
module pmq_dp #(
  parameter int QUEUE_DEPTH = pmq_pkg::PMQ_DEPTH_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  pmq_pkg::pmq_in_t                     in_item,
  input  logic                                 cfg_we,
  input  logic [pmq_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pmq_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  pmq_pkg::pmq_cmd_t                    cmd,
  output pmq_pkg::pmq_status_t                 st,
  output logic                                 out_strobe,
  output pmq_pkg::pmq_out_t                    out_item
);
  import pmq_pkg::*;

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = $bits(pmq_entry_t);

  pmq_in_t        in_r;
  logic [4:0]     high_mark_r;
  logic [3:0]     low_mark_r;
  logic [CW-1:0]  count_r, count_nxt;
  logic [11:0]    bytes_r, bytes_nxt;
  logic           blocked_r, blocked_nxt;
  logic [IW-1:0]  ptr_r;
  logic [IW-1:0]  tag_r;
  logic           scan_v_r;
  logic           shift_v_r;
  pmq_entry_t     best_r, best_nxt;
  logic [IW-1:0]  best_idx_r, best_idx_nxt;
  logic           out_strobe_r;
  pmq_out_t       out_r, out_nxt;

  logic           ram_we;
  logic [IW-1:0]  ram_waddr;
  logic [EW-1:0]  ram_wdata;
  logic           ram_re;
  logic [IW-1:0]  ram_raddr;
  logic [EW-1:0]  ram_rdata;
  pmq_entry_t     rd_entry;
  pmq_entry_t     new_entry;

  pmq_ram #(
    .WIDTH(EW),
    .DEPTH(QUEUE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_entry               = pmq_entry_t'(ram_rdata);
  assign new_entry.priority_val = in_r.msg_priority;
  assign new_entry.payload      = in_r.payload;
  assign new_entry.length       = in_r.msg_len;

  assign ram_re    = cmd.scan_rd | cmd.shift_rd;
  assign ram_raddr = cmd.scan_rd ? ptr_r : ptr_r + IW'(1);
  assign ram_we    = cmd.send_commit | shift_v_r;
  assign ram_waddr = cmd.send_commit ? count_r[IW-1:0] : tag_r;
  assign ram_wdata = cmd.send_commit ? EW'(new_entry) : ram_rdata;

  assign st.is_recv    = (in_r.operation == OP_RECV);
  assign st.send_ok    = (count_r < CW'(QUEUE_DEPTH)) && !blocked_r;
  assign st.empty      = (count_r == '0);
  assign st.scan_last  = (CW'(ptr_r) == count_r - CW'(1));
  assign st.shift_more = ((CW'(ptr_r) + CW'(1)) < count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_mark_r <= HIGH_MARK_RST;
      low_mark_r  <= LOW_MARK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HIGH_MARK: high_mark_r <= cfg_wdata;
        CFG_LOW_MARK:  low_mark_r  <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // scan compare: first read seeds the best entry, later only strictly higher wins
  always_comb begin
    best_nxt     = best_r;
    best_idx_nxt = best_idx_r;
    if (scan_v_r && ((tag_r == '0) || (rd_entry.priority_val > best_r.priority_val))) begin
      best_nxt     = rd_entry;
      best_idx_nxt = tag_r;
    end
  end

  always_comb begin
    count_nxt   = count_r;
    bytes_nxt   = bytes_r;
    blocked_nxt = blocked_r;
    if (cmd.send_commit) begin
      count_nxt = count_r + CW'(1);
      bytes_nxt = bytes_r + 12'(in_r.msg_len);
      if (32'(count_nxt) == 32'(high_mark_r)) begin
        blocked_nxt = 1'b1;
      end
    end else if (cmd.recv_commit) begin
      count_nxt = count_r - CW'(1);
      bytes_nxt = bytes_r - 12'(best_r.length);
      if (32'(count_nxt) == 32'(low_mark_r)) begin
        blocked_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    out_nxt              = '0;
    out_nxt.status       = cmd.refuse ? ST_REFUSED : ST_OK;
    out_nxt.full_flag    = blocked_nxt;
    out_nxt.entry_count  = 5'(count_nxt);
    out_nxt.bytes_held   = bytes_nxt;
    if (cmd.recv_commit) begin
      out_nxt.out_priority = best_r.priority_val;
      out_nxt.out_payload  = best_r.payload;
      out_nxt.out_length   = best_r.length;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      bytes_r      <= '0;
      blocked_r    <= 1'b0;
      scan_v_r     <= 1'b0;
      shift_v_r    <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      bytes_r      <= bytes_nxt;
      blocked_r    <= blocked_nxt;
      scan_v_r     <= cmd.scan_rd;
      shift_v_r    <= cmd.shift_rd;
      out_strobe_r <= cmd.send_commit | cmd.refuse | cmd.recv_commit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r <= in_item;
    end
    if (cmd.ptr_clr) begin
      ptr_r <= '0;
    end else if (cmd.ptr_best) begin
      ptr_r <= best_idx_nxt;
    end else if (cmd.scan_rd || cmd.shift_rd) begin
      ptr_r <= ptr_r + IW'(1);
    end
    tag_r      <= ptr_r;
    best_r     <= best_nxt;
    best_idx_r <= best_idx_nxt;
    out_r      <= out_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_send_legal: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.send_commit |-> (count_r < CW'(QUEUE_DEPTH)) && !blocked_r)
    else $error("send committed while full or blocked");

  a_recv_dec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.recv_commit |=> count_r == $past(count_r) - CW'(1))
    else $error("receive did not remove exactly one entry");

  a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
    shift_v_r |-> (CW'(tag_r) + CW'(1)) < count_r)
    else $error("compaction write outside held entries");

endmodule
